// ===== rtl/core/c2d_pkg.sv =====
`default_nettype none

package c2d_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned MAX_ROWS = 1024;

    typedef enum logic [2:0] {
        CFG_IN_HEIGHT     = 3'd0,
        CFG_IN_WIDTH      = 3'd1,
        CFG_IN_CHANNELS   = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_KERNEL_WIDTH  = 3'd4,
        CFG_NUM_KERNELS   = 3'd5
    } t_cfg_index;

    typedef enum logic {
        KIND_WEIGHT = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    typedef struct packed {
        logic                       kind;
        logic                       frame_start;
        logic [3:0]                 weight_kernel;
        logic [1:0]                 weight_channel;
        logic [2:0]                 weight_row;
        logic [2:0]                 weight_col;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]                 out_row;
        logic [5:0]                 out_col;
        logic [3:0]                 out_kernel;
        logic signed [SUM_W-1:0]    sum;
        logic                       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // one tap read request from the sequencer to the memories
    typedef struct packed {
        logic rd_en;
        logic first;
    } t_tap_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/c2d_line_mem.sv =====
`default_nettype none

module c2d_line_mem #(
    parameter int unsigned DEPTH = 1792
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire logic signed [15:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic signed [15:0]                o_rdata
);

    logic signed [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/c2d_mac.sv =====
`default_nettype none

module c2d_mac (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic                                 i_first,
    input  wire logic signed [15:0]                   i_sample,
    input  wire logic signed [15:0]                   i_weight,
    output logic signed [c2d_pkg::SUM_W-1:0]          o_acc
);

    logic signed [31:0] r_prod;
    logic               r_en;
    logic               r_first;

    always_ff @(posedge i_clk) begin
        r_prod  <= i_sample * i_weight;
        r_en    <= i_en;
        r_first <= i_first;
        if (r_en) begin
            if (r_first) begin
                o_acc <= c2d_pkg::SUM_W'(r_prod);
            end else begin
                o_acc <= o_acc + c2d_pkg::SUM_W'(r_prod);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/conv2d_valid_multichannel.sv =====
// tap walk: a sample that closes a window starts a walk, for each kernel in turn, over
// in_channels*kernel_height*kernel_width taps, one tap per cycle through the shared
// multiply-accumulate and the single read port of each memory; o_stall holds off items
// until the sum of the last kernel is emitted
// reset: synchronous active low; position counters and handshakes clear, registers
// return to 28x28, 1 channel, 3x3, 8 kernels; the memories are not cleared
`default_nettype none

module conv2d_valid_multichannel #(
    parameter int unsigned MAX_WIDTH   = 64,
    parameter int unsigned MAX_CHANNELS = 4,
    parameter int unsigned MAX_KERNEL  = 7,
    parameter int unsigned MAX_KERNELS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_index,
    input  wire logic [c2d_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire c2d_pkg::t_in_item          i_item,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output c2d_pkg::t_out_item              o_item
);

    localparam int unsigned LDEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
    localparam int unsigned WDEPTH = MAX_KERNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int unsigned LA_W = $clog2(LDEPTH);
    localparam int unsigned WA_W = $clog2(WDEPTH);
    localparam int unsigned KR_W = $clog2(MAX_KERNEL);
    localparam int unsigned KR_W1 = (KR_W < 1) ? 1 : KR_W;
    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned KW_W = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;

    logic [10:0] r_in_height;
    logic [6:0]  r_in_width;
    logic [2:0]  r_in_channels;
    logic [2:0]  r_kernel_height;
    logic [2:0]  r_kernel_width;
    logic [4:0]  r_num_kernels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height     <= 11'd28;
            r_in_width      <= 7'd28;
            r_in_channels   <= 3'd1;
            r_kernel_height <= 3'd3;
            r_kernel_width  <= 3'd3;
            r_num_kernels   <= 5'd8;
        end else if (i_cfg_we) begin
            case (c2d_pkg::t_cfg_index'(i_cfg_index))
                c2d_pkg::CFG_IN_HEIGHT:     r_in_height     <= i_cfg_data[10:0];
                c2d_pkg::CFG_IN_WIDTH:      r_in_width      <= i_cfg_data[6:0];
                c2d_pkg::CFG_IN_CHANNELS:   r_in_channels   <= i_cfg_data[2:0];
                c2d_pkg::CFG_KERNEL_HEIGHT: r_kernel_height <= i_cfg_data[2:0];
                c2d_pkg::CFG_KERNEL_WIDTH:  r_kernel_width  <= i_cfg_data[2:0];
                c2d_pkg::CFG_NUM_KERNELS:   r_num_kernels   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) limits
    logic [10:0] eff_h;
    logic [10:0] eff_w;
    logic [6:0]  eff_c;
    logic [3:0]  eff_kh;
    logic [3:0]  eff_kw;
    logic [6:0]  eff_nk;

    always_comb begin
        eff_h = (r_in_height == '0) ? 11'd1 :
                (r_in_height > 11'(c2d_pkg::MAX_ROWS)) ? 11'(c2d_pkg::MAX_ROWS) : r_in_height;
        eff_w = (r_in_width == '0) ? 11'd1 :
                (11'(r_in_width) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(r_in_width);
        eff_c = (r_in_channels == '0) ? 7'd1 :
                (7'(r_in_channels) > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : 7'(r_in_channels);
        eff_kh = (r_kernel_height == '0) ? 4'd1 :
                 (4'(r_kernel_height) > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : 4'(r_kernel_height);
        if (11'(eff_kh) > eff_h) eff_kh = 4'(eff_h);
        eff_kw = (r_kernel_width == '0) ? 4'd1 :
                 (4'(r_kernel_width) > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : 4'(r_kernel_width);
        if (11'(eff_kw) > eff_w) eff_kw = 4'(eff_w);
        eff_nk = (r_num_kernels == '0) ? 7'd1 :
                 (7'(r_num_kernels) > 7'(MAX_KERNELS)) ? 7'(MAX_KERNELS) : 7'(r_num_kernels);
    end

    // position counters
    logic [9:0]     r_row;
    logic [CW-1:0]  r_col;
    logic [CHW-1:0] r_ch;
    logic [9:0]     n_row;
    logic [CW-1:0]  n_col;
    logic [CHW-1:0] n_ch;
    logic [9:0]     cur_row;
    logic [CW-1:0]  cur_col;
    logic [CHW-1:0] cur_ch;

    // row slot in the circular line store, kept beside the row counter
    logic [KR_W1-1:0] r_wslot;
    logic [KR_W1-1:0] n_wslot;
    logic [KR_W1-1:0] cur_slot;
    logic [KR_W1-1:0] org_slot;

    c2d_pkg::t_state r_state;
    c2d_pkg::t_state n_state;

    logic in_acc;
    logic is_sample;
    logic fire;
    assign in_acc = i_valid && !o_stall;
    assign is_sample = (i_item.kind == c2d_pkg::KIND_SAMPLE);

    always_comb begin
        cur_row  = i_item.frame_start ? '0 : r_row;
        cur_col  = i_item.frame_start ? '0 : r_col;
        cur_ch   = i_item.frame_start ? '0 : r_ch;
        cur_slot = i_item.frame_start ? '0 : r_wslot;
        n_row   = cur_row;
        n_col   = cur_col;
        n_ch    = cur_ch;
        n_wslot = cur_slot;
        if (7'(cur_ch) + 7'd1 >= eff_c) begin
            n_ch = '0;
            if (11'(cur_col) + 11'd1 >= eff_w) begin
                n_col = '0;
                if (11'(cur_row) + 11'd1 >= eff_h) begin
                    n_row   = '0;
                    n_wslot = '0;
                end else begin
                    n_row   = cur_row + 10'd1;
                    n_wslot = (32'(cur_slot) == MAX_KERNEL - 1) ? '0 : cur_slot + KR_W1'(1);
                end
            end else begin
                n_col = cur_col + CW'(1);
            end
        end else begin
            n_ch = cur_ch + CHW'(1);
        end
        fire = (7'(cur_ch) == eff_c - 7'd1) && (11'(cur_row) + 11'd1 >= 11'(eff_kh))
               && (11'(cur_col) + 11'd1 >= 11'(eff_kw));
        // slot of the window's top row
        org_slot = (32'(cur_slot) + 1 >= 32'(eff_kh)) ?
                   KR_W1'(32'(cur_slot) + 1 - 32'(eff_kh)) :
                   KR_W1'(32'(cur_slot) + 1 + MAX_KERNEL - 32'(eff_kh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_ch    <= '0;
            r_wslot <= '0;
        end else if (in_acc && is_sample) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_ch    <= n_ch;
            r_wslot <= n_wslot;
        end
    end

    // window origin and tap walk
    logic [9:0]     r_r0;
    logic [CW-1:0]  r_c0;
    logic [KW_W-1:0] r_k;
    logic [CHW-1:0] r_tch;
    logic [3:0]     r_tr;
    logic [3:0]     r_tc;
    logic [KR_W1-1:0] r_slot;
    logic [KR_W1-1:0] r_slot0;
    logic [1:0]     r_drain;

    logic tap_last;
    assign tap_last = (7'(r_tch) == eff_c - 7'd1) && (r_tr == eff_kh - 4'd1)
                      && (r_tc == eff_kw - 4'd1);

    c2d_pkg::t_tap_ctl tap;
    always_comb begin
        tap.rd_en    = (r_state == c2d_pkg::ST_ACCUM);
        tap.first    = (r_tch == '0) && (r_tr == '0) && (r_tc == '0);
    end

    logic out_free;
    assign out_free = !o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            c2d_pkg::ST_IDLE:  if (in_acc && is_sample && fire) n_state = c2d_pkg::ST_ACCUM;
            c2d_pkg::ST_ACCUM: if (tap_last) n_state = c2d_pkg::ST_DRAIN;
            c2d_pkg::ST_DRAIN: if (r_drain == 2'd2) n_state = c2d_pkg::ST_EMIT;
            c2d_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = (7'(r_k) == eff_nk - 7'd1) ? c2d_pkg::ST_IDLE : c2d_pkg::ST_ACCUM;
                end
            end
            default: n_state = c2d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != c2d_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c2d_pkg::ST_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= (r_state == c2d_pkg::ST_DRAIN) ? r_drain + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            c2d_pkg::ST_IDLE: begin
                r_r0    <= cur_row + 10'd1 - 10'(eff_kh);
                r_c0    <= cur_col + CW'(1) - CW'(eff_kw);
                r_slot  <= org_slot;
                r_slot0 <= org_slot;
                r_k     <= '0;
                r_tch   <= '0;
                r_tr    <= '0;
                r_tc    <= '0;
            end
            c2d_pkg::ST_ACCUM: begin
                if (r_tc == eff_kw - 4'd1) begin
                    r_tc <= '0;
                    if (r_tr == eff_kh - 4'd1) begin
                        r_tr <= '0;
                        r_slot <= r_slot0;
                        r_tch <= (7'(r_tch) == eff_c - 7'd1) ? '0 : r_tch + CHW'(1);
                    end else begin
                        r_tr <= r_tr + 4'd1;
                        r_slot <= (32'(r_slot) == MAX_KERNEL - 1) ? '0 : r_slot + KR_W1'(1);
                    end
                end else begin
                    r_tc <= r_tc + 4'd1;
                end
            end
            c2d_pkg::ST_EMIT: if (out_free) r_k <= r_k + KW_W'(1);
            default: ;
        endcase
    end

    // line store
    logic [LA_W-1:0] l_waddr;
    logic [LA_W-1:0] l_raddr;
    logic signed [15:0] l_rdata;
    logic [CW-1:0] tap_col;
    assign tap_col = r_c0 + CW'(r_tc);
    assign l_waddr = LA_W'((32'(cur_slot) * MAX_WIDTH + 32'(cur_col))
                           * MAX_CHANNELS + 32'(cur_ch));
    assign l_raddr = LA_W'((32'(r_slot) * MAX_WIDTH + 32'(tap_col)) * MAX_CHANNELS
                           + 32'(r_tch));

    c2d_line_mem #(.DEPTH(LDEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_sample),
        .i_waddr (l_waddr),
        .i_wdata (i_item.value),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // kernel store
    logic [WA_W-1:0] w_waddr;
    logic [WA_W-1:0] w_raddr;
    logic signed [15:0] w_rdata;
    logic w_ok;
    assign w_ok = (32'(i_item.weight_kernel) < MAX_KERNELS)
                  && (32'(i_item.weight_channel) < MAX_CHANNELS)
                  && (32'(i_item.weight_row) < MAX_KERNEL)
                  && (32'(i_item.weight_col) < MAX_KERNEL);
    assign w_waddr = WA_W'(((32'(i_item.weight_kernel) * MAX_CHANNELS
                   + 32'(i_item.weight_channel)) * MAX_KERNEL + 32'(i_item.weight_row))
                   * MAX_KERNEL + 32'(i_item.weight_col));
    assign w_raddr = WA_W'(((32'(r_k) * MAX_CHANNELS + 32'(r_tch)) * MAX_KERNEL
                   + 32'(r_tr)) * MAX_KERNEL + 32'(r_tc));

    c2d_line_mem #(.DEPTH(WDEPTH)) u_weight (
        .i_clk   (i_clk),
        .i_we    (in_acc && !is_sample && w_ok),
        .i_waddr (w_waddr),
        .i_wdata (i_item.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic r_rd_en;
    logic r_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= tap.rd_en;
        end
        r_first <= tap.first;
    end

    logic signed [c2d_pkg::SUM_W-1:0] acc;
    c2d_mac u_mac (
        .i_clk    (i_clk),
        .i_en     (r_rd_en),
        .i_first  (r_first),
        .i_sample (l_rdata),
        .i_weight (w_rdata),
        .o_acc    (acc)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == c2d_pkg::ST_EMIT && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
        if (r_state == c2d_pkg::ST_EMIT && out_free) begin
            o_item.out_row    <= r_r0;
            o_item.out_col    <= 6'(r_c0);
            o_item.out_kernel <= 4'(r_k);
            o_item.sum        <= acc;
            o_item.last       <= (7'(r_k) == eff_nk - 7'd1);
        end
    end

    ap_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != c2d_pkg::ST_IDLE) |-> o_stall)
        else $error("item taken during window walk");
    ap_drain_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2d_pkg::ST_ACCUM && tap_last) |=> (r_state == c2d_pkg::ST_DRAIN))
        else $error("tap walk did not drain");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/conv2d_valid_multichannel_test.sv =====
`default_nettype none

module conv2d_valid_multichannel_test;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [2:0]                 i_cfg_index;
    logic [c2d_pkg::CFG_W-1:0]  i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    c2d_pkg::t_in_item          i_item;
    logic                       o_valid;
    logic                       i_stall;
    c2d_pkg::t_out_item         o_item;

    conv2d_valid_multichannel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

    // conv state mirror
    logic signed [15:0]         line_mem [0:1791];
    logic signed [15:0]         weight_mem [0:3135];
    logic [c2d_pkg::CFG_W-1:0]  cfg_reg [0:5];
    int                         row_cnt, col_cnt, chan_cnt;
    c2d_pkg::t_out_item         sum_q [$];
    int                         err_cnt;
    bit                         quiet;

    always #2 i_clk = ~i_clk;

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int line_idx(int r, int c, int ch);
        return ((r % 7) * 64 + c) * 4 + ch;
    endfunction

    function automatic int weight_idx(int k, int ch, int r, int c);
        return ((k * 4 + ch) * 7 + r) * 7 + c;
    endfunction

    task automatic predict_conv(input c2d_pkg::t_in_item it);
        int h, w, nch, kh, kw, nk, r0, c0;
        longint acc;
        c2d_pkg::t_out_item o;
        if (it.kind == c2d_pkg::KIND_WEIGHT) begin
            if (it.weight_row < 7 && it.weight_col < 7)
                weight_mem[weight_idx(it.weight_kernel, it.weight_channel,
                                      it.weight_row, it.weight_col)] = it.value;
            return;
        end
        h   = clampi(int'(cfg_reg[c2d_pkg::CFG_IN_HEIGHT][10:0]), 1, 1024);
        w   = clampi(int'(cfg_reg[c2d_pkg::CFG_IN_WIDTH][6:0]), 1, 64);
        nch = clampi(int'(cfg_reg[c2d_pkg::CFG_IN_CHANNELS][2:0]), 1, 4);
        kh  = clampi(clampi(int'(cfg_reg[c2d_pkg::CFG_KERNEL_HEIGHT][2:0]), 1, 7), 1, h);
        kw  = clampi(clampi(int'(cfg_reg[c2d_pkg::CFG_KERNEL_WIDTH][2:0]), 1, 7), 1, w);
        nk  = clampi(int'(cfg_reg[c2d_pkg::CFG_NUM_KERNELS][4:0]), 1, 16);
        if (it.frame_start) begin
            row_cnt = 0;
            col_cnt = 0;
            chan_cnt = 0;
        end
        line_mem[line_idx(row_cnt, col_cnt, chan_cnt)] = it.value;
        if (chan_cnt == nch - 1 && row_cnt + 1 >= kh && col_cnt + 1 >= kw) begin
            r0 = row_cnt + 1 - kh;
            c0 = col_cnt + 1 - kw;
            for (int k = 0; k < nk; k++) begin
                acc = 0;
                for (int ch = 0; ch < nch; ch++)
                    for (int r = 0; r < kh; r++)
                        for (int c = 0; c < kw; c++)
                            acc += longint'(line_mem[line_idx(r0 + r, c0 + c, ch)]) *
                                   longint'(weight_mem[weight_idx(k, ch, r, c)]);
                o.out_row    = r0[9:0];
                o.out_col    = c0[5:0];
                o.out_kernel = k[3:0];
                o.sum        = acc[47:0];
                o.last       = (k == nk - 1);
                sum_q.push_back(o);
            end
        end
        chan_cnt++;
        if (chan_cnt >= nch) begin
            chan_cnt = 0;
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) row_cnt = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        c2d_pkg::t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sum_q.size() == 0) begin
                $error("unexpected result row %0d col %0d", o_item.out_row, o_item.out_col);
                err_cnt++;
            end else begin
                e = sum_q.pop_front();
                if (o_item.out_row !== e.out_row) begin
                    $error("out_row exp %0d got %0d", e.out_row, o_item.out_row);
                    err_cnt++;
                end
                if (o_item.out_col !== e.out_col) begin
                    $error("out_col exp %0d got %0d", e.out_col, o_item.out_col);
                    err_cnt++;
                end
                if (o_item.out_kernel !== e.out_kernel) begin
                    $error("out_kernel exp %0d got %0d", e.out_kernel, o_item.out_kernel);
                    err_cnt++;
                end
                if (o_item.sum !== e.sum) begin
                    $error("sum exp %0d got %0d", e.sum, o_item.sum);
                    err_cnt++;
                end
                if (o_item.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_item.last);
                    err_cnt++;
                end
            end
        end
    end

    // receiver backpressure bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input c2d_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        predict_conv(it);
    endtask

    function automatic c2d_pkg::t_in_item weight_txn(int k, int ch, int r, int c,
                                                     logic [15:0] v);
        c2d_pkg::t_in_item it;
        it.kind           = c2d_pkg::KIND_WEIGHT;
        it.frame_start    = 1'($urandom);
        it.weight_kernel  = k[3:0];
        it.weight_channel = ch[1:0];
        it.weight_row     = r[2:0];
        it.weight_col     = c[2:0];
        it.value          = v;
        return it;
    endfunction

    function automatic c2d_pkg::t_in_item sample_txn(bit fs, logic [15:0] v);
        c2d_pkg::t_in_item it;
        it = c2d_pkg::t_in_item'(30'($urandom));
        it.kind        = c2d_pkg::KIND_SAMPLE;
        it.frame_start = fs;
        it.value       = v;
        return it;
    endfunction

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sum_q.size() != 0) @(posedge i_clk);
        repeat (3300) @(posedge i_clk);
    endtask

    task automatic set_config(input int h, w, nch, kh, kw, nk);
        int v [0:5];
        v = '{h, w, nch, kh, kw, nk};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= v[i][c2d_pkg::CFG_W-1:0];
            @(posedge i_clk);
            cfg_reg[i] = v[i][c2d_pkg::CFG_W-1:0];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_weights(input int nk, nch, kh, kw);
        for (int k = 0; k < nk; k++)
            for (int ch = 0; ch < nch; ch++)
                for (int r = 0; r < kh; r++)
                    for (int c = 0; c < kw; c++)
                        send_item(weight_txn(k, ch, r, c, 16'($urandom)));
    endtask

    task automatic send_frame(input int rows, w, nch, bit fs);
        for (int i = 0; i < rows * w * nch; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(weight_txn($urandom, $urandom, 7, $urandom, 16'($urandom)));
            send_item(sample_txn(fs && i == 0, 16'($urandom)));
        end
    endtask

    task automatic test_extremes();
        set_config(0, 0, 0, 0, 0, 0);
        send_item(weight_txn(0, 0, 0, 0, 16'h8000));
        send_item(sample_txn(1, 16'h8000));
        send_item(sample_txn(0, 16'h7fff));
        send_item(weight_txn(0, 0, 0, 0, 16'h7fff));
        send_item(weight_txn(15, 3, 7, 7, 16'h1234));
        send_item(weight_txn(2, 1, 6, 7, 16'h4321));
        send_item(sample_txn(1, 16'h8000));
        send_item(sample_txn(0, 16'h7fff));
        send_item(sample_txn(0, 16'h0000));
        send_item(sample_txn(0, 16'hffff));
        drain_results();
    endtask

    task automatic test_many_kernels();
        set_config(2047, 1, 1, 1, 1, 31);
        load_weights(16, 1, 1, 1);
        send_frame(1, 1, 1, 1);
        drain_results();
    endtask

    task automatic test_largest_kernel();
        set_config(7, 1, 1, 7, 7, 1);
        load_weights(1, 1, 7, 1);
        send_frame(7, 1, 1, 1);
        drain_results();
        set_config(1, 7, 1, 7, 7, 1);
        load_weights(1, 1, 1, 7);
        send_frame(1, 7, 1, 1);
        drain_results();
    endtask

    task automatic test_wide_row();
        set_config(1, 127, 1, 1, 2, 1);
        load_weights(1, 1, 1, 2);
        send_frame(1, 64, 1, 1);
        drain_results();
    endtask

    task automatic test_random_frames();
        int h, w, nch, kh, kw, nk;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 2) quiet = 1'b1;
            h   = $urandom_range(1, 2);
            w   = $urandom_range(1, 2);
            nch = $urandom_range(1, 4);
            kh  = $urandom_range(1, h);
            kw  = $urandom_range(1, w);
            nk  = $urandom_range(1, 3);
            set_config(h, w, nch, kh, kw, nk);
            load_weights(nk, nch, kh, kw);
            send_frame(h, w, nch, 1);
            if (ph == 1) begin
                i_valid <= 1'b0;
                while (sum_q.size() != 0) @(posedge i_clk);
            end
            drain_results();
        end
    endtask

    initial begin
        err_cnt     = 0;
        quiet       = 1'b0;
        row_cnt     = 0;
        col_cnt     = 0;
        chan_cnt    = 0;
        cfg_reg     = '{11'd28, 11'd28, 11'd1, 11'd3, 11'd3, 11'd8};
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_item      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_many_kernels();
        test_largest_kernel();
        test_wide_row();
        test_random_frames();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
